// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("invariant violated");
// antecedent true implies consequent true in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/dllm_pkg.sv -----
`timescale 1ns / 1ps

package dllm_pkg;

  // fixed field widths
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;
  localparam int POS_W  = 8;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;

  // action codes
  localparam action_t ACT_INSERT = 3'd0;
  localparam action_t ACT_REMOVE = 3'd1;
  localparam action_t ACT_READ   = 3'd2;
  localparam action_t ACT_MODIFY = 3'd3;
  localparam action_t ACT_LOCATE = 3'd4;
  localparam action_t ACT_CLEAR  = 3'd5;

  // status codes
  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_FULL = 2'd1;
  localparam status_t STAT_BAD  = 2'd2;

endpackage

// ----- hdl/doubly_linked_list_manager_core.sv -----
// Doubly linked list manager over a fixed node pool.
// Input word (s_axis_*): tuser carries the action; tdata carries handle,
// data_value and position_index from the low bit up. Every input word
// produces exactly one output word (m_axis_*): tuser carries the status,
// tdata the result handle, read value, links, head, tail and count.
// Nodes live in three pool memories (value, next, prev) plus an in-use
// memory, each with one read and one write port; one shared read address
// and a small sequencer drive them.
// Steps from accept to output: read, modify, remove, error cases and
// unused actions check the handle's node and finish; insert scans for the
// lowest free node (one read per cycle), writes the new node, then patches
// its neighbor; locate follows next links from the head, one per cycle,
// unless the index is out of range or 1; clear sweeps the in-use memory,
// one entry per cycle. One word is worked on at a time; s_axis_tready_o is
// high only while idle, so a new word is taken only once the last result
// has gone to the output register. After reset the in-use memory is swept
// before the first word is taken. The result sits in an output register,
// so a stalled receiver does not stop the next input word; a second result
// waits inside until the register frees up.
`timescale 1ns / 1ps

module doubly_linked_list_manager_core #(
  parameter int NODES      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // handle, data_value, position_index; zero pad to bytes
  input  logic [((($clog2(NODES+1) + VALUE_BITS + dllm_pkg::POS_W) + 7) / 8) * 8 - 1:0]
               s_axis_tdata_i,
  // action
  input  logic [dllm_pkg::ACT_W-1:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // result_handle, read_value, next_handle, prev_handle, first_handle,
  // last_handle, element_count; zero pad to bytes
  output logic [(((6 * $clog2(NODES+1) + VALUE_BITS) + 7) / 8) * 8 - 1:0]
               m_axis_tdata_o,
  // status
  output logic [dllm_pkg::STAT_W-1:0] m_axis_tuser_o
);

  `include "assert_macros.svh"

  localparam int HW     = $clog2(NODES + 1);   // handle / count width
  localparam int AW     = $clog2(NODES);       // pool address width
  localparam int OUT_W  = (((6 * HW + VALUE_BITS) + 7) / 8) * 8;
  localparam int CW     = (HW > dllm_pkg::POS_W) ? HW : dllm_pkg::POS_W;
  localparam logic [HW-1:0] NIL  = HW'(NODES);
  localparam logic [AW-1:0] LAST = AW'(NODES - 1);

  // sequencer states
  localparam logic [3:0] ST_INIT  = 4'd0;  // in-use sweep after reset
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;  // handle's node data back
  localparam logic [3:0] ST_SCAN  = 4'd3;  // lowest free node search
  localparam logic [3:0] ST_INS1  = 4'd4;  // write the new node
  localparam logic [3:0] ST_INS2  = 4'd5;  // patch the neighbor
  localparam logic [3:0] ST_WALK  = 4'd6;  // follow next links
  localparam logic [3:0] ST_CLR   = 4'd7;  // in-use sweep for clear
  localparam logic [3:0] ST_DONE  = 4'd8;  // hand result to output reg

  // input word fields
  logic [HW-1:0]                 in_handle;
  logic signed [VALUE_BITS-1:0]  in_value;
  logic [dllm_pkg::POS_W-1:0]    in_pos;

  assign in_handle = s_axis_tdata_i[HW-1:0];
  assign in_value  = s_axis_tdata_i[HW +: VALUE_BITS];
  assign in_pos    = s_axis_tdata_i[HW + VALUE_BITS +: dllm_pkg::POS_W];

  // pool memories, shared read address, registered read data
  logic signed [VALUE_BITS-1:0] val_mem [NODES];
  logic [HW-1:0]                nxt_mem [NODES];
  logic [HW-1:0]                prv_mem [NODES];
  logic                         use_mem [NODES];

  logic [AW-1:0]                rd_addr;
  logic signed [VALUE_BITS-1:0] val_rd_q;
  logic [HW-1:0]                nxt_rd_q, prv_rd_q;
  logic                         use_rd_q;

  logic                         val_we, nxt_we, prv_we, use_we;
  logic [AW-1:0]                val_wa, nxt_wa, prv_wa, use_wa;
  logic signed [VALUE_BITS-1:0] val_wd;
  logic [HW-1:0]                nxt_wd, prv_wd;
  logic                         use_wd;

  // control state
  logic [3:0]              state_q, state_d;
  logic [HW-1:0]           head_q, head_d, tail_q, tail_d, cnt_q, cnt_d;
  logic [AW-1:0]           scan_q, scan_d;
  logic                    ov_q, ov_d;

  // item and working payload
  dllm_pkg::action_t            act_q, act_d;
  logic [HW-1:0]                h_q, h_d, hn_q, hn_d;
  logic signed [VALUE_BITS-1:0] val_q, val_d, hv_q, hv_d;
  logic [dllm_pkg::POS_W-1:0]   idx_q, idx_d, k_q, k_d, k_nx;
  dllm_pkg::status_t            st_q, st_d;
  logic [HW-1:0]                res_q, res_d, rn_q, rn_d, rp_q, rp_d;
  logic signed [VALUE_BITS-1:0] rv_q, rv_d;

  // output register
  dllm_pkg::status_t            o_st_q, o_st_d;
  logic [HW-1:0]                o_res_q, o_res_d, o_rn_q, o_rn_d, o_rp_q, o_rp_d;
  logic [HW-1:0]                o_first_q, o_first_d, o_last_q, o_last_d;
  logic [HW-1:0]                o_cnt_q, o_cnt_d;
  logic signed [VALUE_BITS-1:0] o_rv_q, o_rv_d;

  logic live, at_append, at_head;
  logic [HW-1:0] new_node;

  assign live      = (h_q < NIL) && use_rd_q;
  assign at_append = (h_q == NIL);
  assign at_head   = !at_append && (h_q == head_q);
  assign new_node  = HW'(scan_q);
  assign k_nx      = k_q + dllm_pkg::POS_W'(1);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    scan_d  = scan_q;
    ov_d    = ov_q;
    act_d   = act_q;
    h_d     = h_q;
    hn_d    = hn_q;
    val_d   = val_q;
    hv_d    = hv_q;
    idx_d   = idx_q;
    k_d     = k_q;
    st_d    = st_q;
    res_d   = res_q;
    rn_d    = rn_q;
    rp_d    = rp_q;
    rv_d    = rv_q;
    o_st_d    = o_st_q;
    o_res_d   = o_res_q;
    o_rv_d    = o_rv_q;
    o_rn_d    = o_rn_q;
    o_rp_d    = o_rp_q;
    o_first_d = o_first_q;
    o_last_d  = o_last_q;
    o_cnt_d   = o_cnt_q;

    rd_addr = '0;
    val_we = 1'b0; val_wa = '0; val_wd = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
    use_we = 1'b0; use_wa = '0; use_wd = 1'b0;

    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_INIT, ST_CLR: begin
        use_we = 1'b1;
        use_wa = scan_q;
        use_wd = 1'b0;
        if (scan_q == LAST) begin
          scan_d  = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end

      ST_IDLE: begin
        rd_addr = in_handle[AW-1:0];
        if (s_axis_tvalid_i) begin
          act_d   = s_axis_tuser_i;
          h_d     = in_handle;
          val_d   = in_value;
          idx_d   = in_pos;
          st_d    = dllm_pkg::STAT_OK;
          res_d   = NIL;
          rv_d    = '0;
          rn_d    = NIL;
          rp_d    = NIL;
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        hv_d    = val_rd_q;
        hn_d    = nxt_rd_q;
        state_d = ST_DONE;
        case (act_q)
          dllm_pkg::ACT_INSERT: begin
            if (!at_append && !live) begin
              st_d = dllm_pkg::STAT_BAD;
            end else if (cnt_q == NIL) begin
              st_d = dllm_pkg::STAT_FULL;
            end else begin
              scan_d  = '0;
              rd_addr = '0;
              state_d = ST_SCAN;
            end
          end
          dllm_pkg::ACT_REMOVE: begin
            if (!live) begin
              st_d = dllm_pkg::STAT_BAD;
            end else begin
              use_we = 1'b1;
              use_wa = h_q[AW-1:0];
              use_wd = 1'b0;
              // unlink: predecessor skips forward, successor skips back
              if (prv_rd_q != NIL) begin
                nxt_we = 1'b1;
                nxt_wa = prv_rd_q[AW-1:0];
                nxt_wd = nxt_rd_q;
              end else begin
                head_d = nxt_rd_q;
              end
              if (nxt_rd_q != NIL) begin
                prv_we = 1'b1;
                prv_wa = nxt_rd_q[AW-1:0];
                prv_wd = prv_rd_q;
              end else begin
                tail_d = prv_rd_q;
              end
              if (cnt_q != '0) begin
                cnt_d = cnt_q - HW'(1);
              end
            end
          end
          dllm_pkg::ACT_READ: begin
            if (!live) begin
              st_d = dllm_pkg::STAT_BAD;
            end else begin
              rv_d = val_rd_q;
              rn_d = nxt_rd_q;
              rp_d = prv_rd_q;
            end
          end
          dllm_pkg::ACT_MODIFY: begin
            if (!live) begin
              st_d = dllm_pkg::STAT_BAD;
            end else begin
              val_we = 1'b1;
              val_wa = h_q[AW-1:0];
              val_wd = val_q;
            end
          end
          dllm_pkg::ACT_LOCATE: begin
            if ((idx_q == '0) || (CW'(idx_q) > CW'(cnt_q))) begin
              res_d = NIL;
            end else if (idx_q == dllm_pkg::POS_W'(1)) begin
              res_d = head_q;
            end else begin
              rd_addr = head_q[AW-1:0];
              k_d     = dllm_pkg::POS_W'(1);
              state_d = ST_WALK;
            end
          end
          dllm_pkg::ACT_CLEAR: begin
            head_d  = NIL;
            tail_d  = NIL;
            cnt_d   = '0;
            scan_d  = '0;
            state_d = ST_CLR;
          end
          default: begin
            // unused codes: no change, status ok
          end
        endcase
      end

      ST_SCAN: begin
        if (!use_rd_q) begin
          state_d = ST_INS1;
        end else begin
          scan_d  = scan_q + AW'(1);
          rd_addr = scan_q + AW'(1);
        end
      end

      ST_INS1: begin
        use_we = 1'b1;
        use_wa = scan_q;
        use_wd = 1'b1;
        val_we = 1'b1;
        val_wa = scan_q;
        nxt_we = 1'b1;
        nxt_wa = scan_q;
        prv_we = 1'b1;
        prv_wa = scan_q;
        if (at_append) begin
          val_wd = val_q;
          nxt_wd = NIL;
          prv_wd = tail_q;
        end else if (at_head) begin
          val_wd = val_q;
          nxt_wd = head_q;
          prv_wd = NIL;
        end else begin
          // new node follows the handle and inherits its value
          val_wd = hv_q;
          nxt_wd = hn_q;
          prv_wd = h_q;
        end
        state_d = ST_INS2;
      end

      ST_INS2: begin
        res_d = new_node;
        cnt_d = cnt_q + HW'(1);
        if (at_append) begin
          if (tail_q != NIL) begin
            nxt_we = 1'b1;
            nxt_wa = tail_q[AW-1:0];
            nxt_wd = new_node;
          end else begin
            head_d = new_node;
          end
          tail_d = new_node;
        end else if (at_head) begin
          prv_we = 1'b1;
          prv_wa = head_q[AW-1:0];
          prv_wd = new_node;
          head_d = new_node;
        end else begin
          val_we = 1'b1;
          val_wa = h_q[AW-1:0];
          val_wd = val_q;
          nxt_we = 1'b1;
          nxt_wa = h_q[AW-1:0];
          nxt_wd = new_node;
          if (hn_q != NIL) begin
            prv_we = 1'b1;
            prv_wa = hn_q[AW-1:0];
            prv_wd = new_node;
          end else begin
            tail_d = new_node;
          end
        end
        state_d = ST_DONE;
      end

      ST_WALK: begin
        if (k_nx == idx_q) begin
          res_d   = nxt_rd_q;
          state_d = ST_DONE;
        end else begin
          rd_addr = nxt_rd_q[AW-1:0];
          k_d     = k_nx;
        end
      end

      ST_DONE: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d      = 1'b1;
          o_st_d    = st_q;
          o_res_d   = res_q;
          o_rv_d    = rv_q;
          o_rn_d    = rn_q;
          o_rp_d    = rp_q;
          o_first_d = head_q;
          o_last_d  = tail_q;
          o_cnt_d   = cnt_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // pool memories
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    val_rd_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nxt_rd_q <= nxt_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    prv_rd_q <= prv_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    use_rd_q <= use_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      head_q  <= NIL;
      tail_q  <= NIL;
      cnt_q   <= '0;
      scan_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    h_q       <= h_d;
    hn_q      <= hn_d;
    val_q     <= val_d;
    hv_q      <= hv_d;
    idx_q     <= idx_d;
    k_q       <= k_d;
    st_q      <= st_d;
    res_q     <= res_d;
    rv_q      <= rv_d;
    rn_q      <= rn_d;
    rp_q      <= rp_d;
    o_st_q    <= o_st_d;
    o_res_q   <= o_res_d;
    o_rv_q    <= o_rv_d;
    o_rn_q    <= o_rn_d;
    o_rp_q    <= o_rp_d;
    o_first_q <= o_first_d;
    o_last_q  <= o_last_d;
    o_cnt_q   <= o_cnt_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = o_st_q;
  assign m_axis_tdata_o  = OUT_W'({o_cnt_q, o_last_q, o_first_q, o_rp_q, o_rn_q,
                                   o_rv_q, o_res_q});

  // empty list has neither head nor tail, and vice versa
  `ASSERT_ALWAYS(a_head_vs_count, clk_i, rst_ni, (head_q == NIL) == (cnt_q == '0))
  `ASSERT_ALWAYS(a_tail_vs_count, clk_i, rst_ni, (tail_q == NIL) == (cnt_q == '0))
  // a node is only allocated when the pool has room
  `ASSERT_IMPL(a_alloc_room, clk_i, rst_ni, state_q == ST_INS1, cnt_q < NIL)

endmodule
